[rtl/tun_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and types of the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int Q_BITS          = 15;
    localparam int OUT_WIDTH       = 16;
    localparam int SCALE_SHIFT     = 30;

    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

endpackage
`default_nettype wire

[rtl/triangle_unit_normal_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit
// Unit face normal of one triangle per item, in signed Q1.14.
//
// Channel   Signals                                   Direction
// command   start, busy, i_a_* .. i_c_*               in (busy out)
// result    o_valid, o_normal_x/y/z, o_degenerate     out
//
// One item is taken in every cycle while busy is low.
// The pipeline holds the edge, cross product and square stages, one stage
// for each of the 15 quotient bits, and the output register.
// busy is set by reset, cleared at the first clock edge after reset is released, and low from then on.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module triangle_unit_normal_unit #(
    parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_z,
    output logic                               o_valid,
    output logic signed [15:0]                 o_normal_x,
    output logic signed [15:0]                 o_normal_y,
    output logic signed [15:0]                 o_normal_z,
    output logic                               o_degenerate
);
    import tun_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = 2 * (CW + 1);
    localparam int SSW = 4 * (CW + 1) + 2;
    localparam int RW  = SSW + 34;

    logic                           r_busy;
    logic                           w_accept;
    logic [2:0][CW-1:0]             w_a;
    logic [2:0][CW-1:0]             w_b;
    logic [2:0][CW-1:0]             w_c;
    logic                           w_xvalid;
    logic [2:0][MW-1:0]             w_mag;
    logic [2:0]                     w_xneg;
    t_ctl                           w_ctl [0:Q_BITS];
    logic [SSW-1:0]                 w_s   [0:Q_BITS];
    logic [2:0][RW-1:0]             w_r   [0:Q_BITS];
    logic [2:0][RW-1:0]             w_u   [0:Q_BITS];
    logic [2:0][Q_BITS-1:0]         w_q   [0:Q_BITS];
    logic [2:0]                     w_neg [0:Q_BITS];
    logic [2:0][OUT_WIDTH-1:0]      n_val;
    logic                           r_valid;
    logic [2:0][OUT_WIDTH-1:0]      r_val;
    logic                           r_degen;

    assign w_accept = start && !r_busy;
    assign w_a = {i_a_z, i_a_y, i_a_x};
    assign w_b = {i_b_z, i_b_y, i_b_x};
    assign w_c = {i_c_z, i_c_y, i_c_x};

    tun_cross #(.CW(CW)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_valid (w_xvalid),
        .o_mag   (w_mag),
        .o_neg   (w_xneg)
    );

    tun_square #(.CW(CW)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xvalid),
        .i_mag   (w_mag),
        .i_neg   (w_xneg),
        .o_ctl   (w_ctl[0]),
        .o_s     (w_s[0]),
        .o_r     (w_r[0]),
        .o_u     (w_u[0]),
        .o_neg   (w_neg[0])
    );

    assign w_q[0] = '0;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_quot
        tun_quot_stage #(.CW(CW), .BIT(Q_BITS - 1 - g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_s     (w_s[g]),
            .i_r     (w_r[g]),
            .i_u     (w_u[g]),
            .i_q     (w_q[g]),
            .i_neg   (w_neg[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_s     (w_s[g+1]),
            .o_r     (w_r[g+1]),
            .o_u     (w_u[g+1]),
            .o_q     (w_q[g+1]),
            .o_neg   (w_neg[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_ctl[Q_BITS].degen) begin
                n_val[i] = '0;
            end else if (w_neg[Q_BITS][i]) begin
                n_val[i] = OUT_WIDTH'(0) - OUT_WIDTH'(w_q[Q_BITS][i]);
            end else begin
                n_val[i] = OUT_WIDTH'(w_q[Q_BITS][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= w_ctl[Q_BITS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_degen <= w_ctl[Q_BITS].degen;
    end

    assign busy         = r_busy;
    assign o_valid      = r_valid;
    assign o_normal_x   = r_val[0];
    assign o_normal_y   = r_val[1];
    assign o_normal_z   = r_val[2];
    assign o_degenerate = r_degen;

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            (o_normal_x == 16'sd0 && o_normal_y == 16'sd0 && o_normal_z == 16'sd0))
        else $error("degenerate result with a nonzero normal");

    a_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |->
            (o_normal_x != 16'sd0 || o_normal_y != 16'sd0 || o_normal_z != 16'sd0))
        else $error("zero normal for a triangle with nonzero area");

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384 &&
             o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384 &&
             o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384))
        else $error("normal component beyond unit magnitude");

endmodule
`default_nettype wire

[rtl/tun_cross.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, cross product partial products and component magnitudes
// over three register stages.
// ----------------------------------------------------------------------------
module tun_cross #(
    parameter int CW = tun_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [2:0][CW-1:0]          i_a,
    input  wire logic [2:0][CW-1:0]          i_b,
    input  wire logic [2:0][CW-1:0]          i_c,
    output logic                             o_valid,
    output logic [2:0][2*(CW+1)-1:0]         o_mag,
    output logic [2:0]                       o_neg
);
    import tun_pkg::*;

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;

    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic [2:0][EW-1:0]   r_e1;
    logic [2:0][EW-1:0]   r_e2;
    logic [2:0][PW-1:0]   r_pp;
    logic [2:0][PW-1:0]   r_pq;
    logic [2:0][PW-1:0]   r_mag;
    logic [2:0]           r_neg;
    logic [2:0][NW-1:0]   n_n;
    logic [2:0][NW-1:0]   n_abs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_n[i]   = {r_pp[i][PW-1], r_pp[i]} - {r_pq[i][PW-1], r_pq[i]};
            n_abs[i] = n_n[i][NW-1] ? (~n_n[i] + NW'(1)) : n_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= {i_b[i][CW-1], i_b[i]} - {i_a[i][CW-1], i_a[i]};
            r_e2[i] <= {i_c[i][CW-1], i_c[i]} - {i_a[i][CW-1], i_a[i]};
        end
        r_pp[0] <= $signed(r_e1[1]) * $signed(r_e2[2]);
        r_pq[0] <= $signed(r_e1[2]) * $signed(r_e2[1]);
        r_pp[1] <= $signed(r_e1[2]) * $signed(r_e2[0]);
        r_pq[1] <= $signed(r_e1[0]) * $signed(r_e2[2]);
        r_pp[2] <= $signed(r_e1[0]) * $signed(r_e2[1]);
        r_pq[2] <= $signed(r_e1[1]) * $signed(r_e2[0]);
        for (int i = 0; i < 3; i++) begin
            r_mag[i] <= n_abs[i][PW-1:0];
            r_neg[i] <= n_n[i][NW-1];
        end
    end

    assign o_valid = r_v3;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule
`default_nettype wire

[rtl/tun_square.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tun_square
// Squares of the component magnitudes from half-width partial products,
// their sum, and the starting remainders of the quotient search.
// ----------------------------------------------------------------------------
module tun_square #(
    parameter int CW = tun_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [2:0][2*(CW+1)-1:0]      i_mag,
    input  wire logic [2:0]                    i_neg,
    output tun_pkg::t_ctl                      o_ctl,
    output logic [4*(CW+1)+1:0]                o_s,
    output logic [2:0][4*(CW+1)+35:0]          o_r,
    output logic [2:0][4*(CW+1)+35:0]          o_u,
    output logic [2:0]                         o_neg
);
    import tun_pkg::*;

    localparam int LW  = CW + 1;
    localparam int MW  = 2 * LW;
    localparam int SW  = 2 * MW;
    localparam int SSW = SW + 2;
    localparam int RW  = SW + 36;

    logic                  r_v4;
    logic                  r_v5;
    logic                  r_v6;
    t_ctl                  r_ctl;
    logic [2:0][MW-1:0]    r_hh;
    logic [2:0][MW-1:0]    r_hl;
    logic [2:0][MW-1:0]    r_ll;
    logic [2:0]            r_neg4;
    logic [2:0]            r_neg5;
    logic [2:0]            r_neg6;
    logic [2:0]            r_neg7;
    logic [2:0][SW-1:0]    r_sq;
    logic [2:0][SW-1:0]    r_sq6;
    logic [SSW-1:0]        r_s6;
    logic [SSW-1:0]        r_s;
    logic [2:0][RW-1:0]    r_r;
    logic [2:0][RW-1:0]    r_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_ctl <= '0;
        end else begin
            r_v4      <= i_valid;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_ctl.valid <= r_v6;
            r_ctl.degen <= (r_s6 == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_hh[i] <= i_mag[i][MW-1:LW] * i_mag[i][MW-1:LW];
            r_hl[i] <= i_mag[i][MW-1:LW] * i_mag[i][LW-1:0];
            r_ll[i] <= i_mag[i][LW-1:0] * i_mag[i][LW-1:0];
            r_sq[i] <= {r_hh[i], {MW{1'b0}}} + (SW'(r_hl[i]) << (LW + 1))
                       + SW'(r_ll[i]);
            r_r[i]  <= (RW'(r_sq6[i]) << SCALE_SHIFT) - RW'(r_s6);
            r_u[i]  <= RW'(0) - RW'(r_s6);
        end
        r_sq6  <= r_sq;
        r_s6   <= SSW'(r_sq[0]) + SSW'(r_sq[1]) + SSW'(r_sq[2]);
        r_s    <= r_s6;
        r_neg4 <= i_neg;
        r_neg5 <= r_neg4;
        r_neg6 <= r_neg5;
        r_neg7 <= r_neg6;
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_u   = r_u;
    assign o_neg = r_neg7;

endmodule
`default_nettype wire

[rtl/tun_quot_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tun_quot_stage
// One bit of the rounded quotient search for all three components, kept
// exact by updating the remainder and the odd multiple with shifts and adds.
// ----------------------------------------------------------------------------
module tun_quot_stage #(
    parameter int CW  = tun_pkg::COORD_WIDTH_DEF,
    parameter int BIT = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tun_pkg::t_ctl                      i_ctl,
    input  wire logic [4*(CW+1)+1:0]                i_s,
    input  wire logic [2:0][4*(CW+1)+35:0]          i_r,
    input  wire logic [2:0][4*(CW+1)+35:0]          i_u,
    input  wire logic [2:0][tun_pkg::Q_BITS-1:0]    i_q,
    input  wire logic [2:0]                         i_neg,
    output tun_pkg::t_ctl                           o_ctl,
    output logic [4*(CW+1)+1:0]                     o_s,
    output logic [2:0][4*(CW+1)+35:0]               o_r,
    output logic [2:0][4*(CW+1)+35:0]               o_u,
    output logic [2:0][tun_pkg::Q_BITS-1:0]         o_q,
    output logic [2:0]                              o_neg
);
    import tun_pkg::*;

    localparam int SSW = 4 * (CW + 1) + 2;
    localparam int RW  = SSW + 34;

    t_ctl                     r_ctl;
    logic [SSW-1:0]           r_s;
    logic [2:0][RW-1:0]       r_r;
    logic [2:0][RW-1:0]       r_u;
    logic [2:0][Q_BITS-1:0]   r_q;
    logic [2:0]               r_neg;
    logic [2:0][RW-1:0]       n_t;
    logic [2:0]               n_acc;
    logic [2:0][RW-1:0]       n_r;
    logic [2:0][RW-1:0]       n_u;
    logic [2:0][Q_BITS-1:0]   n_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]   = i_r[i] - (i_u[i] << (BIT + 2)) - (RW'(i_s) << (2 * BIT + 2));
            n_acc[i] = !n_t[i][RW-1] && !i_q[i][Q_BITS-1];
            n_r[i]   = n_acc[i] ? n_t[i] : i_r[i];
            n_u[i]   = n_acc[i] ? (i_u[i] + (RW'(i_s) << (BIT + 1))) : i_u[i];
            n_q[i]   = n_acc[i] ? (i_q[i] | (Q_BITS'(1) << BIT)) : i_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= i_s;
        r_r   <= n_r;
        r_u   <= n_u;
        r_q   <= n_q;
        r_neg <= i_neg;
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_u   = r_u;
    assign o_q   = r_q;
    assign o_neg = r_neg;

endmodule
`default_nettype wire
